// File: design/base64url_decoder_defines.svh
// Assertion macros used by the decoder top level.
`ifndef BASE64URL_DECODER_DEFINES_SVH
`define BASE64URL_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define B64D_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decoder check failed");

// Next-cycle implication, checked outside reset.
`define B64D_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decoder check failed");

`endif

// File: design/b64d_pkg.sv
`default_nettype none

package b64d_pkg;

  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [5:0] SYM_MINUS = 6'd62;
  localparam logic [5:0] SYM_UNDER = 6'd63;

  // Character classes.
  localparam logic [1:0] KIND_SYM = 2'd0;
  localparam logic [1:0] KIND_PAD = 2'd1;
  localparam logic [1:0] KIND_BAD = 2'd2;

  // Final status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADCHAR  = 2'd1;
  localparam logic [1:0] ST_LEFTOVER = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] value;
    logic       last;
  } item_t;

endpackage

`default_nettype wire

// File: design/b64d_front.sv
`default_nettype none

module b64d_front (
  input  wire logic             push,
  output logic                  full,
  input  wire logic [7:0]       in_char,
  input  wire logic             is_last,
  input  wire logic             q_full,
  output logic                  q_push,
  output b64d_pkg::item_t       q_item
);

  logic [1:0] kind;
  logic [5:0] value;

  // Map the character onto the url-safe alphabet.
  always_comb begin
    kind  = b64d_pkg::KIND_SYM;
    value = '0;
    if (in_char >= 8'h41 && in_char <= 8'h5A) begin
      value = 6'(in_char - 8'h41);
    end else if (in_char >= 8'h61 && in_char <= 8'h7A) begin
      value = 6'(in_char - 8'h61 + 8'd26);
    end else if (in_char >= 8'h30 && in_char <= 8'h39) begin
      value = 6'(in_char - 8'h30 + 8'd52);
    end else if (in_char == b64d_pkg::CH_MINUS) begin
      value = b64d_pkg::SYM_MINUS;
    end else if (in_char == b64d_pkg::CH_UNDER) begin
      value = b64d_pkg::SYM_UNDER;
    end else if (in_char == b64d_pkg::CH_PAD) begin
      kind = b64d_pkg::KIND_PAD;
    end else begin
      kind = b64d_pkg::KIND_BAD;
    end
  end

  assign full         = q_full;
  assign q_push       = push && !q_full;
  assign q_item.kind  = kind;
  assign q_item.value = value;
  assign q_item.last  = is_last;

endmodule

`default_nettype wire

// File: design/b64d_queue.sv
`default_nettype none

module b64d_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire b64d_pkg::item_t  wr_item,
  output logic                  q_full,
  input  wire logic             rd_en,
  output logic                  rd_valid,
  output b64d_pkg::item_t       rd_item
);

  logic            head_valid;
  logic            tail_valid;
  b64d_pkg::item_t head;
  b64d_pkg::item_t tail;
  logic            head_free;

  assign q_full    = tail_valid;
  assign rd_valid  = head_valid;
  assign rd_item   = head;
  assign head_free = !head_valid || rd_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else if (head_free) begin
      // Advance the tail into the head, or let a new transaction fall through.
      head_valid <= tail_valid || wr_en;
      tail_valid <= tail_valid && wr_en;
    end else if (wr_en) begin
      tail_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_free) begin
      if (tail_valid) begin
        head <= tail;
        tail <= wr_item;
      end else begin
        head <= wr_item;
      end
    end else if (wr_en) begin
      tail <= wr_item;
    end
  end

endmodule

`default_nettype wire

// File: design/b64d_back.sv
`default_nettype none

module b64d_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire b64d_pkg::item_t  q_item,
  output logic                  q_pop,
  output logic                  empty,
  input  wire logic             pop,
  output logic [7:0]            out_byte,
  output logic                  byte_valid,
  output logic                  done_res,
  output logic [1:0]            status
);

  logic [5:0]  bit_buffer;
  logic [2:0]  bits_held;
  logic        pad_seen;
  logic        bad_char_seen;
  logic        out_valid;

  logic [5:0]  bit_buffer_next;
  logic [2:0]  bits_held_next;
  logic        pad_seen_next;
  logic        bad_char_seen_next;
  logic [7:0]  byte_next;
  logic        valid_next;
  logic [1:0]  status_next;
  logic [11:0] joined;
  logic [2:0]  rem;
  logic [5:0]  keep_mask;
  logic        take;

  assign take  = q_valid && (!out_valid || pop);
  assign q_pop = take;
  assign empty = !out_valid;

  always_comb begin
    bit_buffer_next    = bit_buffer;
    bits_held_next     = bits_held;
    pad_seen_next      = pad_seen;
    bad_char_seen_next = bad_char_seen;
    byte_next          = '0;
    valid_next         = 1'b0;
    status_next        = b64d_pkg::ST_OK;
    joined             = {bit_buffer, q_item.value};
    rem                = bits_held - 3'd2;
    keep_mask          = (6'd1 << rem) - 6'd1;

    if (!pad_seen && !bad_char_seen) begin
      case (q_item.kind)
        b64d_pkg::KIND_PAD: begin
          pad_seen_next = 1'b1;
        end
        b64d_pkg::KIND_SYM: begin
          if (bits_held != 3'd0) begin
            // A byte is complete; keep only the bits below it.
            byte_next       = 8'(joined >> rem);
            valid_next      = 1'b1;
            bits_held_next  = rem;
            bit_buffer_next = q_item.value & keep_mask;
          end else begin
            bits_held_next  = 3'd6;
            bit_buffer_next = q_item.value;
          end
        end
        default: begin
          bad_char_seen_next = 1'b1;
        end
      endcase
    end

    if (q_item.last) begin
      if (bad_char_seen_next) begin
        status_next = b64d_pkg::ST_BADCHAR;
      end else if (bit_buffer_next != 6'd0) begin
        status_next = b64d_pkg::ST_LEFTOVER;
      end
      bit_buffer_next    = '0;
      bits_held_next     = '0;
      pad_seen_next      = 1'b0;
      bad_char_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer    <= '0;
      bits_held     <= '0;
      pad_seen      <= 1'b0;
      bad_char_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        bit_buffer    <= bit_buffer_next;
        bits_held     <= bits_held_next;
        pad_seen      <= pad_seen_next;
        bad_char_seen <= bad_char_seen_next;
        out_valid     <= 1'b1;
      end else if (pop) begin
        out_valid     <= 1'b0;
      end
    end
  end

  // Hold the result until it is popped.
  always_ff @(posedge clk) begin
    if (take) begin
      out_byte   <= byte_next;
      byte_valid <= valid_next;
      done_res   <= q_item.last;
      status     <= status_next;
    end
  end

endmodule

`default_nettype wire

// File: design/base64url_decoder.sv
// Unpadded base64url decoder, one character per transaction.
// Input channel: drive in_char and is_last with push; a transaction is taken
// at a clock edge where push is high and full is low. Raise is_last on the
// final character of each string.
// Result channel: while empty is low, out_byte, byte_valid, done_res and
// status show the oldest result; pop takes it at an edge where empty is low.
// Every input transaction yields exactly one result, in order.
// Path: the classifier writes the two-entry queue at the input edge, and the
// decode stage loads its output register from the queue head at a later edge,
// once that register is empty or being popped. Throughput: one character per
// cycle while pop keeps the output register drained, set by the single decode
// stage, which updates the bit buffer once per transaction.
// When pop stays low, the output register holds its result, the queue fills
// after two more transactions and full rises; no result is lost or dropped.
// Reset (rst, synchronous) empties the queue and output register and clears
// the bit buffer, padding and error flags; the same state clears after
// every final character.
`default_nettype none

`include "base64url_decoder_defines.svh"

module base64url_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_char,
  input  wire logic       is_last,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            done_res,
  output logic [1:0]      status
);

  logic            q_full;
  logic            q_push;
  b64d_pkg::item_t q_wr_item;
  logic            q_pop;
  logic            q_valid;
  b64d_pkg::item_t q_rd_item;

  b64d_front u_front (
    .push    (push),
    .full    (full),
    .in_char (in_char),
    .is_last (is_last),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_wr_item)
  );

  b64d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_item  (q_wr_item),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_item  (q_rd_item)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_rd_item),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .done_res   (done_res),
    .status     (status)
  );

  // A full queue means the output register is stalled with a result.
  `B64D_ASSERT_NOW(a_full_implies_result, clk, rst, full, !empty)
  // A result without a byte carries a zero byte.
  `B64D_ASSERT_NOW(a_no_byte_is_zero, clk, rst, !empty && !byte_valid, out_byte == 8'd0)
  // Status is only reported on the final character.
  `B64D_ASSERT_NOW(a_status_only_at_done, clk, rst, !empty && !done_res,
                   status == b64d_pkg::ST_OK)
  // A stalled queue head must still be there after the edge.
  `B64D_ASSERT_NEXT(a_queue_head_held, clk, rst, q_valid && !q_pop, q_valid)

endmodule

`default_nettype wire
